FILE: src/lgs_pkg.sv
package lgs_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   // Size registers and the stream's row counter: wide enough to hold the maximum itself.
   localparam int CNT_W = 11;
   // Column cells kept between requests. The window's left column is the previous centre and
   // its right column comes straight from the request; both are dead at the row borders.
   localparam int WIN_COLS = 2;

   typedef struct packed {
      logic shift;
      logic clear;
      logic drop;
   } cell_ctrl_type;

   typedef struct packed {
      logic             wr_en;
      logic [COL_W-1:0] wr_addr;
      logic [1:0]       wr_data;
      logic [COL_W-1:0] rd_addr;
   } ls_req_type;

   // Each window column holds the cells top (bit 0), middle (bit 1) and bottom (bit 2).
   function automatic logic life_next(input logic [2:0] left, input logic [2:0] centre,
                                      input logic [2:0] right);
      logic [7:0] nbr;
      logic [3:0] n;
      nbr = {left, right, centre[0], centre[2]};
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, nbr[i]};
      end
      if (centre[1]) begin
         life_next = (n == 4'd2) || (n == 4'd3);
      end else begin
         life_next = (n == 4'd3);
      end
   endfunction

endpackage

FILE: src/lgs_window_cell.sv
module lgs_window_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lgs_pkg::cell_ctrl_type ctrl,
   input  logic [2:0]            col_in,
   output logic [2:0]            col_out
);

   logic [2:0] col_ff;
   logic [2:0] col_in_next;

   always_comb begin
      col_in_next = col_ff;
      if (ctrl.clear) begin
         col_in_next = 3'd0;
      end else if (ctrl.shift) begin
         col_in_next = ctrl.drop ? 3'd0 : col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 3'd0;
      end else begin
         col_ff <= col_in_next;
      end
   end

   assign col_out = col_ff;

endmodule

FILE: src/lgs_line_store.sv
module lgs_line_store (
   input  logic                clock,
   input  lgs_pkg::ls_req_type req,
   output logic [1:0]          rd_data
);

   logic [1:0] store_ff [lgs_pkg::MAX_COLS];
   logic [1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         store_ff[req.wr_addr] <= req.wr_data;
      end
   end

   // A write to the address being read is passed straight through.
   always_ff @(posedge clock) begin
      if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
         rd_ff <= req.wr_data;
      end else begin
         rd_ff <= store_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

FILE: src/life_generation_stencil_unit.sv
// Streaming Conway generation (birth on 3, survival on 2 or 3) over a bounded board.
// Requests carry one cell each in raster order (req_op low) or a flush tick (req_op high).
// The block takes one request per clock while req_stall is low. A result is registered on
// the request that completes its neighbourhood, the request col_count+1 places after the
// cell itself; after the last cell send col_count+1 flush requests.
// rsp_frame_last marks the final cell, after which the next request is cell (0,0).
// Two registers at byte addresses 0 (row_count) and 4 (col_count) size the board; a
// write restarts the stream. Sizes of 0 act as 1, sizes above 1024 act as 1024.
// The neighbourhood is the incoming column beside a chain of two column cells, fed by a
// two-bit-wide line store of one entry per column; the store is read ahead of each request,
// so its one read and one write port carry one request per clock while req_stall is low.
// Reset sets both sizes to 64 and restarts the stream; the line store is not cleared,
// as stale entries are masked at the top border.
// When rsp_stall is high a second result is held in a skid register; req_stall rises
// only while that skid register is occupied.
module life_generation_stencil_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic        req_alive,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_next_alive,
   output logic [9:0]  rsp_out_row,
   output logic [9:0]  rsp_out_col,
   output logic        rsp_frame_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW = lgs_pkg::CNT_W;
   localparam int AW = lgs_pkg::COL_W;
   localparam int NC = lgs_pkg::WIN_COLS;

   typedef struct packed {
      logic       next_alive;
      logic [9:0] row;
      logic [9:0] col;
      logic       last;
   } result_type;

   function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] size,
                                                input logic [CW-1:0] max_size);
      if (size == '0) begin
         clamp_size = CW'(1);
      end else if (size > max_size) begin
         clamp_size = max_size;
      end else begin
         clamp_size = size;
      end
   endfunction

   logic [CW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] col_count_ff, col_count_in;
   logic [CW-1:0] in_row_ff, in_row_in;
   logic [AW-1:0] in_col_ff, in_col_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          skid_valid_ff, skid_valid_in;
   result_type    out_ff, out_in;
   result_type    skid_ff, skid_in;

   logic [CW-1:0] rows, cols;
   logic          cfg_wr, accept, out_take;
   logic          c_zero, row_ge1, row_ge2;
   logic          cell_v, top_b, mid_b;
   logic [2:0]    col3, right_col;
   logic          emit, last, restart;
   logic [CW-1:0] er, ec, col_next;
   logic          wrap;
   result_type    res;
   logic [1:0]    ls_rd;
   lgs_pkg::ls_req_type ls_req;
   lgs_pkg::cell_ctrl_type cell_ctrl [NC];
   logic [2:0]    cell_in [NC];
   logic [2:0]    col_q [NC];

   assign rows = clamp_size(row_count_ff, CW'(lgs_pkg::MAX_ROWS));
   assign cols = clamp_size(col_count_ff, CW'(lgs_pkg::MAX_COLS));

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = paddr[2] ? {{(32 - CW){1'b0}}, col_count_ff}
                            : {{(32 - CW){1'b0}}, row_count_ff};

   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !skid_valid_ff;
   assign out_take = rsp_valid_ff && !rsp_stall;

   assign c_zero = (in_col_ff == '0);
   assign row_ge1 = (in_row_ff != '0);
   assign row_ge2 = (in_row_ff >= CW'(2));

   // Rows past the board carry no cell, whatever the request says.
   assign cell_v = !req_op && req_alive && (in_row_ff < rows);
   assign top_b = row_ge2 && ls_rd[1];
   assign mid_b = row_ge1 && ls_rd[0];
   assign col3 = {cell_v, mid_b, top_b};

   // At the first column the window's right side lies beyond the board edge.
   assign right_col = c_zero ? 3'd0 : col3;

   // At the first column the finished row is two rows back, so it runs one row further.
   assign emit = c_zero ? (row_ge2 && (in_row_ff <= rows + CW'(1)))
                        : (row_ge1 && (in_row_ff <= rows));
   assign er = c_zero ? (in_row_ff - CW'(2)) : (in_row_ff - CW'(1));
   assign ec = c_zero ? (cols - CW'(1)) : ({1'b0, in_col_ff} - CW'(1));
   assign last = (er == rows - CW'(1)) && (ec == cols - CW'(1));

   assign res.next_alive = lgs_pkg::life_next(col_q[0], col_q[1], right_col);
   assign res.row = er[9:0];
   assign res.col = ec[9:0];
   assign res.last = last;

   assign restart = cfg_wr || (accept && emit && last);
   assign col_next = {1'b0, in_col_ff} + CW'(1);
   assign wrap = (col_next >= cols);

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      if (restart) begin
         in_col_in = '0;
         in_row_in = '0;
      end else if (accept) begin
         if (wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + CW'(1);
         end else begin
            in_col_in = col_next[AW-1:0];
         end
      end
   end

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (cfg_wr) begin
         if (paddr[2]) begin
            col_count_in = pwdata[CW-1:0];
         end else begin
            row_count_in = pwdata[CW-1:0];
         end
      end
   end

   assign ls_req.wr_en = accept;
   assign ls_req.wr_addr = in_col_ff;
   assign ls_req.wr_data = {mid_b, cell_v};
   assign ls_req.rd_addr = in_col_in;

   lgs_line_store u_line_store (
      .clock   (clock),
      .req     (ls_req),
      .rd_data (ls_rd)
   );

   for (genvar k = 0; k < NC; k++) begin : g_cell
      assign cell_ctrl[k].shift = accept;
      assign cell_ctrl[k].clear = restart;
      assign cell_ctrl[k].drop = (k == NC - 1) ? 1'b0 : c_zero;
      assign cell_in[k] = (k == NC - 1) ? col3 : col_q[(k + 1) % NC];

      lgs_window_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (cell_ctrl[k]),
         .col_in  (cell_in[k]),
         .col_out (col_q[k])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in = out_ff;
      skid_in = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && emit) begin
         if (!rsp_valid_ff || out_take) begin
            out_in = res;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CW'(64);
         col_count_ff <= CW'(64);
         in_row_ff <= '0;
         in_col_ff <= '0;
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         in_row_ff <= in_row_in;
         in_col_ff <= in_col_in;
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_next_alive = out_ff.next_alive;
   assign rsp_out_row = out_ff.row;
   assign rsp_out_col = out_ff.col;
   assign rsp_frame_last = out_ff.last;

endmodule

FILE: dv/lgs_tb_pkg.sv
package lgs_tb_pkg;

   typedef enum logic {
      OP_CELL  = 1'b0,
      OP_FLUSH = 1'b1
   } stream_op_type;

   localparam logic [2:0] ADDR_ROW_COUNT = 3'd0;
   localparam logic [2:0] ADDR_COL_COUNT = 3'd4;

   // A size of zero behaves as one, and anything beyond the maximum as the maximum.
   function automatic int board_extent(input logic [lgs_pkg::CNT_W-1:0] setting,
                                       input int limit);
      if (setting == 0) return 1;
      if (setting > limit) return limit;
      return int'(setting);
   endfunction

endpackage

FILE: dv/life_generation_checker.sv
module life_generation_checker
   import lgs_pkg::*;
   import lgs_tb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_op,
   input  logic               req_alive,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_next_alive,
   input  logic [ROW_W-1:0]   rsp_out_row,
   input  logic [COL_W-1:0]   rsp_out_col,
   input  logic               rsp_frame_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int unsigned        fail_count,
   output int unsigned        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic             next_alive;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             frame_last;
   } generation_cell_type;

   logic [CNT_W-1:0] rows_reg;
   logic [CNT_W-1:0] cols_reg;
   // Bit 0 holds the row above, bit 1 the row above that, one entry per column.
   logic [1:0]       column_history [MAX_COLS];
   // Three columns of three cells; the centre cell is bit 4.
   logic [8:0]       neighbourhood;
   int               at_row;
   int               at_col;
   generation_cell_type next_generation_q [$];

   function automatic void restart_stream();
      at_row = 0;
      at_col = 0;
      neighbourhood = '0;
   endfunction

   task automatic step_generation(input stream_op_type op, input logic alive);
      int rows;
      int cols;
      int col_at;
      int out_r;
      int out_c;
      int n;
      logic fresh;
      logic above;
      logic above2;
      logic [2:0] column;
      logic [8:0] view;
      bit emits;
      generation_cell_type result;
      rows = board_extent(rows_reg, MAX_ROWS);
      cols = board_extent(cols_reg, MAX_COLS);
      fresh = (op == OP_CELL) ? alive : 1'b0;
      if (at_col >= cols) at_col = 0;
      // Below the board every request is a flush, whatever it carries.
      if (at_row >= rows) fresh = 1'b0;
      col_at = at_col;
      above = (at_row >= 1) ? column_history[col_at][0] : 1'b0;
      above2 = (at_row >= 2) ? column_history[col_at][1] : 1'b0;
      column = {fresh, above, above2};
      column_history[col_at] = {above, fresh};
      emits = 1'b0;
      out_r = 0;
      out_c = 0;
      if (col_at != 0) begin
         view = {column, neighbourhood[8:3]};
         neighbourhood = view;
         if (at_row >= 1 && at_row - 1 < rows) begin
            emits = 1'b1;
            out_r = at_row - 1;
            out_c = col_at - 1;
         end
      end else begin
         // The right border of the finished row and the left border of the new one are dead.
         view = {3'b000, neighbourhood[8:3]};
         neighbourhood = {column, 6'd0};
         if (at_row >= 2 && at_row - 2 < rows) begin
            emits = 1'b1;
            out_r = at_row - 2;
            out_c = cols - 1;
         end
      end
      at_col++;
      if (at_col >= cols) begin
         at_col = 0;
         at_row++;
      end
      if (emits) begin
         n = $countones({view[8:5], view[3:0]});
         result.next_alive = (n == 3) || (view[4] && n == 2);
         result.row = out_r[ROW_W-1:0];
         result.col = out_c[COL_W-1:0];
         result.frame_last = (out_r == rows - 1) && (out_c == cols - 1);
         next_generation_q.push_back(result);
         if (result.frame_last) restart_stream();
      end
   endtask

   task automatic log_failure(input bit orphan, input generation_cell_type want,
                              input generation_cell_type seen);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         if (orphan) begin
            $display("%0t: result with no request behind it: next_alive=%0b row=%0d col=%0d",
                     $realtime, seen.next_alive, seen.row, seen.col);
         end else begin
            $display("%0t: expected next_alive=%0b row=%0d col=%0d frame_last=%0b",
                     $realtime, want.next_alive, want.row, want.col, want.frame_last);
            $display("%0t:      got next_alive=%0b row=%0d col=%0d frame_last=%0b",
                     $realtime, seen.next_alive, seen.row, seen.col, seen.frame_last);
         end
      end
   endtask

   always @(posedge clock) begin
      generation_cell_type seen;
      generation_cell_type want;
      if (reset) begin
         rows_reg = CNT_W'(64);
         cols_reg = CNT_W'(64);
         foreach (column_history[i]) column_history[i] = 2'b00;
         restart_stream();
         next_generation_q.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               ADDR_ROW_COUNT: begin
                  rows_reg = pwdata[CNT_W-1:0];
                  restart_stream();
               end
               ADDR_COL_COUNT: begin
                  cols_reg = pwdata[CNT_W-1:0];
                  restart_stream();
               end
               default: ;
            endcase
         end
         // Results leave only after their request was taken, so they are matched first.
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_next_alive, rsp_out_row, rsp_out_col, rsp_frame_last};
            if (next_generation_q.size() == 0) begin
               log_failure(1'b1, seen, seen);
            end else begin
               want = next_generation_q.pop_front();
               if (seen.next_alive !== want.next_alive || seen.row !== want.row ||
                   seen.col !== want.col || seen.frame_last !== want.frame_last) begin
                  log_failure(1'b0, want, seen);
               end
            end
         end
         if (req_valid && !req_stall) step_generation(stream_op_type'(req_op), req_alive);
      end
      pending = next_generation_q.size();
   end

endmodule

FILE: dv/tb_life_generation_stencil_unit.sv
module tb_life_generation_stencil_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import lgs_pkg::*;
   import lgs_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int RANDOM_REQUESTS = 500;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic             req_op;
   logic             req_alive;
   logic             rsp_valid;
   logic             rsp_stall;
   logic             rsp_next_alive;
   logic [9:0]       rsp_out_row;
   logic [9:0]       rsp_out_col;
   logic             rsp_frame_last;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [2:0]       paddr;
   logic [31:0]      pwdata;
   logic [31:0]      prdata;
   logic             pready;

   int unsigned      mismatches;
   int unsigned      in_flight;
   int unsigned      cycles = 0;
   int unsigned      requests_sent = 0;
   bit               quiet_sender = 1'b0;
   bit               quiet_receiver = 1'b0;
   int               rows_now = 64;
   int               cols_now = 64;

   life_generation_stencil_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_alive      (req_alive),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_alive (rsp_next_alive),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   life_generation_checker u_generation_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_alive      (req_alive),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_alive (rsp_next_alive),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .fail_count     (mismatches),
      .pending        (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_span(input bit quiet);
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [CNT_W-1:0] pick_extent();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return '0;
      if (pick < 75) return CNT_W'($urandom_range(1, 6));
      return CNT_W'($urandom_range(7, 14));
   endfunction

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && !quiet_receiver && $urandom_range(0, 2) == 0) begin
            stall_left = idle_span(1'b0);
         end
         rsp_stall = (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // Called at a falling edge; returns at the falling edge after the request was taken,
   // with valid still high so that a back-to-back request keeps it high.
   task automatic push_request(input stream_op_type op, input logic alive);
      int gap;
      gap = idle_span(quiet_sender);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_alive = alive;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   // Requests that produce nothing may still sit in the block after the last result.
   task automatic settle();
      req_valid = 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_size(input logic [2:0] addr, input logic [CNT_W-1:0] value);
      logic [31:0] data;
      data = 32'(value);
      // Bits above the register width must be dropped by the block.
      if ($urandom_range(0, 3) == 0) data[31:CNT_W] = (32 - CNT_W)'($urandom);
      settle();
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      if (addr == ADDR_ROW_COUNT) rows_now = board_extent(value, MAX_ROWS);
      else cols_now = board_extent(value, MAX_COLS);
   endtask

   // A full board followed by its flush requests; noise swaps the kind of some requests.
   task automatic play_board(input int density, input int noise);
      for (int r = 0; r < rows_now; r++) begin
         for (int c = 0; c < cols_now; c++) begin
            push_request(($urandom_range(0, 99) < noise) ? OP_FLUSH : OP_CELL,
                         $urandom_range(0, 99) < density);
         end
      end
      for (int f = 0; f <= cols_now; f++) begin
         push_request(($urandom_range(0, 99) < noise) ? OP_CELL : OP_FLUSH,
                      1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int choice;
      int cut;
      int phase_start;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_CELL;
      req_alive = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A few rows at the reset sizes, then a size write cuts the board short.
      repeat (3 * 64) push_request(OP_CELL, 1'($urandom_range(0, 1)));
      write_size(ADDR_ROW_COUNT, CNT_W'(3));
      write_size(ADDR_COL_COUNT, CNT_W'(3));

      // A vertical blinker turns horizontal.
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) push_request(OP_CELL, c == 1);
      end
      repeat (4) push_request(OP_FLUSH, 1'b0);

      write_size(ADDR_ROW_COUNT, CNT_W'(2));
      write_size(ADDR_COL_COUNT, CNT_W'(2));
      // A flush in a cell slot counts as a dead cell, which is then born.
      push_request(OP_FLUSH, 1'b1);
      repeat (3) push_request(OP_CELL, 1'b1);
      // A cell in a flush slot is treated as a flush.
      push_request(OP_CELL, 1'b1);
      push_request(OP_FLUSH, 1'b1);
      push_request(OP_FLUSH, 1'b0);

      // Zero sizes behave as a single-cell board.
      write_size(ADDR_ROW_COUNT, '0);
      write_size(ADDR_COL_COUNT, '0);
      push_request(OP_CELL, 1'b1);
      push_request(OP_CELL, 1'b1);
      push_request(OP_FLUSH, 1'b0);

      // An oversized row setting acts as the maximum, so a single column keeps producing
      // results well past any small height; a size write then restarts the stream.
      write_size(ADDR_ROW_COUNT, '1);
      write_size(ADDR_COL_COUNT, CNT_W'(1));
      repeat (40) push_request(OP_CELL, 1'($urandom_range(0, 1)));
      write_size(ADDR_ROW_COUNT, CNT_W'(4));

      phase_start = requests_sent;
      while (requests_sent - phase_start < RANDOM_REQUESTS) begin
         quiet_sender = ($urandom_range(0, 5) == 0);
         quiet_receiver = ($urandom_range(0, 5) == 0);
         choice = $urandom_range(0, 99);
         if (choice < 20) begin
            write_size(ADDR_ROW_COUNT, pick_extent());
            write_size(ADDR_COL_COUNT, pick_extent());
         end else if (choice < 30) begin
            write_size($urandom_range(0, 1) ? ADDR_ROW_COUNT : ADDR_COL_COUNT, pick_extent());
         end
         if (choice < 88) begin
            play_board($urandom_range(10, 80), (choice % 4 == 0) ? 4 : 0);
         end else begin
            cut = $urandom_range(1, rows_now * cols_now + cols_now);
            repeat (cut) begin
               if (choice >= 95) begin
                  push_request(stream_op_type'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
               end else begin
                  push_request(OP_CELL, 1'($urandom_range(0, 1)));
               end
            end
            // The board was left unfinished; a size write restarts the stream.
            write_size(ADDR_COL_COUNT, pick_extent());
         end
      end

      settle();
      if (mismatches == 0 && in_flight == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
